// File: sv/udc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the seconds-to-calendar converter.
// No dependencies; used by every module of the block.
package udc_pkg;

  // Time of day fields, carried alongside the date computation.
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
  } udc_tod_t;

  // Pipeline control shared by all stages.
  typedef struct packed {
    logic en;
    logic vld;
  } udc_ctl_t;

  // Reciprocals for the constant divisions.
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;  // 2^37 / 60, rounded up
  localparam int unsigned SHIFT_60 = 37;
  localparam logic [17:0] RECIP_3 = 18'd174763;      // 2^19 / 3, rounded up
  localparam int unsigned SHIFT_3 = 19;
  localparam logic [12:0] RECIP_100 = 13'd5243;      // 2^19 / 100, rounded up
  localparam logic [5:0] RECIP_25 = 6'd41;           // 2^10 / 25, rounded up
  localparam logic [11:0] RECIP_YEAR = 12'd2871;     // 2^20 / 365.2425

  // Day count of 1970-01-01 from the common era origin.
  localparam logic [19:0] EPOCH_DAYS_CE = 20'd719499;
  // Offset that moves the day count to the March year boundary of 1969.
  localparam logic [16:0] MARCH_OFFSET = 17'd306;
  localparam logic [11:0] YEAR_BASE = 12'd1968;

  // Cumulative days before March-based month m, that is 367*m/12.
  localparam logic [8:0] CUM_DAYS [1:12] = '{
    9'd30, 9'd61, 9'd91, 9'd122, 9'd152, 9'd183,
    9'd214, 9'd244, 9'd275, 9'd305, 9'd336, 9'd367
  };

endpackage

// File: sv/udc_split.sv
`timescale 1ns / 1ps
// Splits a seconds count into seconds, minutes, hours and whole days.
// Six stages of constant reciprocal multiplies; depends on udc_pkg.
module udc_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  udc_pkg::udc_ctl_t ctl_i,
  input  logic [31:0]      secs_i,
  output logic             vld_o,
  output logic [15:0]      days_o,
  output udc_pkg::udc_tod_t tod_o
);

  logic [5:0]  vld_q;
  logic [31:0] t_a_q;
  logic [63:0] p1_q;
  logic [26:0] q1_b_q, q1_c_q;
  logic [58:0] p2_q;
  logic [20:0] q2_d_q, q2_e_q;
  logic [36:0] p3_q;
  logic [15:0] days_q;
  logic [5:0]  sec_b_q, sec_c_q, sec_d_q, sec_e_q, sec_f_q;
  logic [5:0]  min_d_q, min_e_q, min_f_q;
  logic [4:0]  hr_q;

  logic [63:0] p1_d;
  logic [26:0] q1_d;
  logic [31:0] rem1;
  logic [58:0] p2_d;
  logic [20:0] q2_d;
  logic [26:0] rem2;
  logic [36:0] p3_d;
  logic [15:0] days_d;
  logic [20:0] rem3;

  always_comb begin
    p1_d   = 64'(secs_i) * 64'(udc_pkg::RECIP_60);
    q1_d   = p1_q[63:udc_pkg::SHIFT_60];
    rem1   = t_a_q - 32'(q1_d) * 32'd60;
    p2_d   = 59'(q1_b_q) * 59'(udc_pkg::RECIP_60);
    q2_d   = p2_q[57:udc_pkg::SHIFT_60];
    rem2   = q1_c_q - 27'(q2_d) * 27'd60;
    p3_d   = 37'(q2_d_q[20:3]) * 37'(udc_pkg::RECIP_3);
    days_d = p3_q[34:udc_pkg::SHIFT_3];
    rem3   = q2_e_q - 21'(days_d) * 21'd24;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[4:0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      t_a_q   <= secs_i;
      p1_q    <= p1_d;
      q1_b_q  <= q1_d;
      sec_b_q <= rem1[5:0];
      q1_c_q  <= q1_b_q;
      sec_c_q <= sec_b_q;
      p2_q    <= p2_d;
      q2_d_q  <= q2_d;
      min_d_q <= rem2[5:0];
      sec_d_q <= sec_c_q;
      p3_q    <= p3_d;
      q2_e_q  <= q2_d_q;
      min_e_q <= min_d_q;
      sec_e_q <= sec_d_q;
      days_q  <= days_d;
      hr_q    <= rem3[4:0];
      min_f_q <= min_e_q;
      sec_f_q <= sec_e_q;
    end
  end

  // The stage-A copy of the count feeds the remainder in stage B only.
  assign vld_o      = vld_q[5];
  assign days_o     = days_q;
  assign tod_o.sec  = sec_f_q;
  assign tod_o.min  = min_f_q;
  assign tod_o.hr   = hr_q;

endmodule

// File: sv/udc_year.sv
`timescale 1ns / 1ps
// Finds the March-based year of a day count and the day within that year.
// Estimate by reciprocal, then a three-way correction; depends on udc_pkg.
module udc_year (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  udc_pkg::udc_ctl_t ctl_i,
  input  logic [15:0]      days_i,
  output logic             vld_o,
  output logic [11:0]      year_o,
  output logic [8:0]       doy_o
);

  logic [3:0]  vld_q;
  logic [19:0] t_a_q, t_b_q, t_c_q;
  logic [28:0] pe_q;
  logic [11:0] c_q [3];
  logic [11:0] c_c_q [3];
  logic [19:0] y365_q [3];
  logic [9:0]  y4_q [3];
  logic [4:0]  y100_q [3];
  logic [3:0]  y400_q [3];
  logic [19:0] dby_q [3];
  logic [11:0] year_q;
  logic [8:0]  doy_q;

  logic [16:0] u;
  logic [7:0]  ye;
  logic [11:0] c_d [3];
  logic [23:0] p100 [3];
  logic [13:0] p400 [3];
  logic [19:0] doy_full;
  logic [11:0] year_d;
  logic [19:0] dby_sel;

  always_comb begin
    u  = 17'(days_i) + udc_pkg::MARCH_OFFSET;
    ye = pe_q[27:20];
    for (int k = 0; k < 3; k++) begin
      c_d[k]  = udc_pkg::YEAR_BASE + 12'(ye) + 12'(k);
      p100[k] = 24'(c_d[k]) * 24'(udc_pkg::RECIP_100);
      p400[k] = 14'(c_d[k][11:4]) * 14'(udc_pkg::RECIP_25);
    end
    // Take the latest candidate whose March start lies before the day.
    if (t_c_q > dby_q[2] + 20'd30) begin
      year_d  = c_c_q[2];
      dby_sel = dby_q[2];
    end else if (t_c_q > dby_q[1] + 20'd30) begin
      year_d  = c_c_q[1];
      dby_sel = dby_q[1];
    end else begin
      year_d  = c_c_q[0];
      dby_sel = dby_q[0];
    end
    doy_full = t_c_q - dby_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[2:0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      t_a_q <= 20'(days_i) + udc_pkg::EPOCH_DAYS_CE;
      pe_q  <= 29'(u) * 29'(udc_pkg::RECIP_YEAR);
      t_b_q <= t_a_q;
      t_c_q <= t_b_q;
      for (int k = 0; k < 3; k++) begin
        c_q[k]    <= c_d[k];
        y365_q[k] <= 20'(c_d[k]) * 20'd365;
        y4_q[k]   <= c_d[k][11:2];
        y100_q[k] <= p100[k][23:19];
        y400_q[k] <= p400[k][13:10];
        c_c_q[k]  <= c_q[k];
        dby_q[k]  <= y365_q[k] + 20'(y4_q[k]) - 20'(y100_q[k]) + 20'(y400_q[k]);
      end
      year_q <= year_d;
      doy_q  <= doy_full[8:0];
    end
  end

  assign vld_o  = vld_q[3];
  assign year_o = year_q;
  assign doy_o  = doy_q;

endmodule

// File: sv/udc_month.sv
`timescale 1ns / 1ps
// Finds the month and day of month, then moves to a January-based year.
// Two stages against the cumulative day table of udc_pkg.
module udc_month (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  udc_pkg::udc_ctl_t ctl_i,
  input  logic [11:0]      year_i,
  input  logic [8:0]       doy_i,
  output logic             vld_o,
  output logic [4:0]       mday_o,
  output logic [3:0]       month_o,
  output logic [11:0]      year_o
);

  logic [1:0]  vld_q;
  logic [3:0]  mon_q;
  logic [8:0]  doy_q;
  logic [11:0] year_a_q, year_q;
  logic [4:0]  mday_q;
  logic [3:0]  month_q;

  logic [3:0]  mon_d;
  logic [8:0]  mday_full;
  logic [3:0]  mon_jan;
  logic [11:0] year_d;

  always_comb begin
    // The month count is one plus the months whose start the day has passed.
    mon_d = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (doy_i > udc_pkg::CUM_DAYS[m]) mon_d = mon_d + 4'd1;
    end
    mday_full = doy_q - udc_pkg::CUM_DAYS[mon_q];
    if (mon_q > 4'd10) begin
      mon_jan = mon_q - 4'd10;
      year_d  = year_a_q + 12'd1;
    end else begin
      mon_jan = mon_q + 4'd2;
      year_d  = year_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      mon_q    <= mon_d;
      doy_q    <= doy_i;
      year_a_q <= year_i;
      mday_q   <= mday_full[4:0];
      month_q  <= mon_jan;
      year_q   <= year_d;
    end
  end

  assign vld_o   = vld_q[1];
  assign mday_o  = mday_q;
  assign month_o = month_q;
  assign year_o  = year_q;

endmodule

// File: sv/unix_seconds_to_calendar_date.sv
`timescale 1ns / 1ps
// Top level of the Unix seconds to Gregorian calendar converter.
// Instantiates udc_split, udc_year and udc_month; depends on udc_pkg.
//
//   Channel  Signals                               Direction
//   input    valid_i, stall_o, unix_seconds_i      word in
//   output   valid_o, stall_i, second_o .. year_o  word out
//
// From acceptance to its result a word passes these stages: six split
// off seconds, minutes and hours, four find the year, two find the month.
// A new word can enter in every cycle; the whole pipeline advances together.
// When the output word is held by stall_i, every stage freezes and stall_o
// rises, so nothing is lost or repeated. Reset clears only the valid bits.
module unix_seconds_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] unix_seconds_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_o,
  output logic [11:0] year_o
);

  // The pipeline moves unless a finished word waits at the output.
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  udc_pkg::udc_ctl_t ctl_split, ctl_year, ctl_month;
  logic              split_vld, year_vld;
  logic [15:0]       days;
  udc_pkg::udc_tod_t tod;
  logic [11:0]       year_mar;
  logic [8:0]        doy;

  assign ctl_split = '{en: en, vld: valid_i};
  assign ctl_year  = '{en: en, vld: split_vld};
  assign ctl_month = '{en: en, vld: year_vld};

  udc_split u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_split),
    .secs_i (unix_seconds_i),
    .vld_o  (split_vld),
    .days_o (days),
    .tod_o  (tod)
  );

  udc_year u_year (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_year),
    .days_i (days),
    .vld_o  (year_vld),
    .year_o (year_mar),
    .doy_o  (doy)
  );

  udc_month u_month (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_month),
    .year_i  (year_mar),
    .doy_i   (doy),
    .vld_o   (valid_o),
    .mday_o  (day_of_month_o),
    .month_o (month_o),
    .year_o  (year_o)
  );

  // Time of day waits out the six date stages in a delay line.
  udc_pkg::udc_tod_t tod_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tod_q[0] <= tod;
      for (int k = 1; k < 6; k++) begin
        tod_q[k] <= tod_q[k-1];
      end
    end
  end

  assign second_o = tod_q[5].sec;
  assign minute_o = tod_q[5].min;
  assign hour_o   = tod_q[5].hr;

  // Assertions.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("stall_o raised with no word at the output");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (month_o != 4'd0 && month_o <= 4'd12))
    else $error("month out of range");

  a_mday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (day_of_month_o != 5'd0))
    else $error("day of month is zero");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (second_o < 6'd60 && minute_o < 6'd60 && hour_o < 5'd24))
    else $error("time of day out of range");

endmodule

// File: tb/udc_checker.sv
`timescale 1ns / 1ps
// Checker for the seconds-to-calendar converter: predicts each date and compares it.
// Watches both channels of the block; depends on nothing but the port widths.
module udc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [31:0] unix_seconds_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [5:0]  second_o,
  input  logic [5:0]  minute_o,
  input  logic [4:0]  hour_o,
  input  logic [4:0]  day_of_month_o,
  input  logic [3:0]  month_o,
  input  logic [11:0] year_o,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [4:0]  mday;
    logic [3:0]  mon;
    logic [11:0] yr;
  } date_t;

  date_t dates_due[$];

  function automatic int unsigned days_to_year(int unsigned y);
    return y * 365 + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic date_t to_date(logic [31:0] secs);
    date_t d;
    int unsigned t, yr, mon;
    t = secs;
    d.sec = 6'(t % 60);
    t = t / 60;
    d.min = 6'(t % 60);
    t = t / 60;
    d.hr = 5'(t % 24);
    t = t / 24 + 719499;
    // Years start in March so the leap day closes the year.
    yr = 1969;
    while (t > days_to_year(yr + 1) + 30) yr++;
    t -= days_to_year(yr);
    mon = 1;
    while (mon < 12 && t > (367 * (mon + 1)) / 12) mon++;
    t -= (367 * mon) / 12;
    d.mday = 5'(t);
    mon += 2;
    if (mon > 12) begin
      mon -= 12;
      yr++;
    end
    d.mon = 4'(mon);
    d.yr = 12'(yr);
    return d;
  endfunction

  assign pending_o = dates_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    date_t want, got;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (valid_i && !stall_o) dates_due.push_back(to_date(unix_seconds_i));
      if (valid_o && !stall_i) begin
        got = {second_o, minute_o, hour_o, day_of_month_o, month_o, year_o};
        if (dates_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = dates_due.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch expected %0d-%0d-%0d %0d:%0d:%0d",
                      " actual %0d-%0d-%0d %0d:%0d:%0d"},
                     $time, want.yr, want.mon, want.mday, want.hr, want.min, want.sec,
                     year_o, month_o, day_of_month_o, hour_o, minute_o, second_o);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/unix_seconds_to_calendar_date_tb.sv
`timescale 1ns / 1ps
// Testbench top for the seconds-to-calendar converter: stimulus and verdict.
// Depends on unix_seconds_to_calendar_date and udc_checker.
module unix_seconds_to_calendar_date_tb;

  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic [31:0] unix_seconds_i = '0;
  logic        stall_i = 1'b0;
  logic        stall_o, valid_o;
  logic [5:0]  second_o, minute_o;
  logic [4:0]  hour_o, day_of_month_o;
  logic [3:0]  month_o;
  logic [11:0] year_o;
  int          errors, pending;
  int          cycles = 0;
  int          send_idle = 23, recv_idle = 48;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  unix_seconds_to_calendar_date dut (.*);

  udc_checker checker_i (.*, .errors_o(errors), .pending_o(pending));

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk_i) stall_i <= ($urandom_range(99) < recv_idle);

  // A hard limit guards against a hung pipeline.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One count in four falls anywhere; the rest sit near the range ends or a leap day.
  function automatic logic [31:0] random_seconds();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'd86400 * 800);
      2: return 32'd951782400 + $urandom_range(32'd86400 * 3); // leap day 2000
      default: return 32'hFFFF_FFFF - $urandom_range(32'd86400 * 60);
    endcase
  endfunction

  // Present one word, optionally after a random gap, and hold it until accepted.
  task automatic send_word(logic [31:0] secs);
    while ($urandom_range(99) < send_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    unix_seconds_i <= secs;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  logic [31:0] directed [] = '{
    32'd0, 32'hFFFF_FFFF, 32'd59, 32'd3599, 32'd86399, 32'd86400,
    32'd5097599,   // end of February in a common year (1970)
    32'd68169599, 32'd68169600,  // the day before the leap day of 1972 and the leap day
    32'd951868799, 32'd951868800, // leap day of 2000, a leap century year
    32'd4107542399, 32'd4107542400, // end of February 2100, not a leap year
    32'd946684799, 32'd946684800, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h8000_0000, 32'h7FFF_FFFF
  };

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_word(directed[i]);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
      recv_idle = (phase == 0) ? 48 : (phase == 1) ? 23 : 0;
      repeat (170) send_word(random_seconds());
    end
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/udc_pkg.sv
sv/udc_split.sv
sv/udc_year.sv
sv/udc_month.sv
sv/unix_seconds_to_calendar_date.sv
tb/udc_checker.sv
tb/unix_seconds_to_calendar_date_tb.sv
